FILE: sv/i2cms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared types and constants of the I2C master bit sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

    // Bit count register width; also holds the recovery pulse limit
    localparam int BIT_CNT_W       = 4;
    localparam int PHASE_W         = 2;
    localparam int BYTE_W          = 8;
    localparam int BYTE_BITS       = 8;
    localparam int RECOVER_PULSES  = 9;
    localparam int QUEUE_DEPTH     = 2;

    // Slot command codes
    typedef enum logic [2:0] {
        KIND_TICK     = 3'd0,
        KIND_START    = 3'd1,
        KIND_STOP     = 3'd2,
        KIND_WRITE    = 3'd3,
        KIND_READ     = 3'd4,
        KIND_SEND_ACK = 3'd5,
        KIND_RECV_ACK = 3'd6,
        KIND_RECOVER  = 3'd7
    } t_kind;

    // Classified slot, as queued between front and back
    typedef struct packed {
        t_kind               kind;
        logic                is_cmd;
        logic [BYTE_W-1:0]   seed;
        logic                sda;
    } t_slot_item;

    // One result beat
    typedef struct packed {
        logic                scl_level;
        logic                sda_level;
        logic                busy_res;
        logic                done_res;
        logic [BYTE_W-1:0]   read_byte;
        logic                ack_seen;
        logic                bus_stuck;
        logic                rejected;
    } t_slot_res;

    // Queue status seen by the front end
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_stat;

endpackage

FILE: sv/i2cms_item_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_item_if
// Input slot channel: valid/ready handshake with the slot fields.
// ----------------------------------------------------------------------------
interface i2cms_item_if;
    logic                          valid;
    logic                          ready;
    logic [2:0]                    kind;
    logic [i2cms_pkg::BYTE_W-1:0]  write_byte;
    logic                          ack_value;
    logic                          sda_sample;

    modport source (output valid, kind, write_byte, ack_value, sda_sample, input ready);
    modport sink   (input valid, kind, write_byte, ack_value, sda_sample, output ready);
endinterface

FILE: sv/i2cms_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_res_if
// Result channel: valid/ready handshake with line drives and status.
// ----------------------------------------------------------------------------
interface i2cms_res_if;
    logic                          valid;
    logic                          ready;
    logic                          scl_level;
    logic                          sda_level;
    logic                          busy_res;
    logic                          done_res;
    logic [i2cms_pkg::BYTE_W-1:0]  read_byte;
    logic                          ack_seen;
    logic                          bus_stuck;
    logic                          rejected;

    modport source (output valid, scl_level, sda_level, busy_res, done_res, read_byte,
                    ack_seen, bus_stuck, rejected, input ready);
    modport sink   (input valid, scl_level, sda_level, busy_res, done_res, read_byte,
                    ack_seen, bus_stuck, rejected, output ready);
endinterface

FILE: sv/i2cms_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_front
// Accepts slot beats, classifies the command and builds the shift seed.
// ----------------------------------------------------------------------------
module i2cms_front (
    i2cms_item_if.sink               i_item,
    input  i2cms_pkg::t_queue_stat   i_qstat,
    output logic                     o_push,
    output i2cms_pkg::t_slot_item    o_entry
);

    i2cms_pkg::t_kind w_kind;

    assign w_kind       = i2cms_pkg::t_kind'(i_item.kind);
    assign i_item.ready = !i_qstat.full;
    assign o_push       = i_item.valid && !i_qstat.full;

    // Classify: command or plain tick, and preload for write / send ack
    always_comb begin
        o_entry.kind   = w_kind;
        o_entry.is_cmd = (w_kind != i2cms_pkg::KIND_TICK);
        o_entry.sda    = i_item.sda_sample;
        case (w_kind)
            i2cms_pkg::KIND_WRITE:    o_entry.seed = i_item.write_byte;
            i2cms_pkg::KIND_SEND_ACK: o_entry.seed = {{(i2cms_pkg::BYTE_W-1){1'b0}},
                                                      i_item.ack_value};
            default:                  o_entry.seed = '0;
        endcase
    end

endmodule

FILE: sv/i2cms_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_queue
// Short register queue between the front end and the slot engine.
// ----------------------------------------------------------------------------
module i2cms_queue #(
    parameter int DEPTH = i2cms_pkg::QUEUE_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  i2cms_pkg::t_slot_item    i_entry,
    input  logic                     i_pop,
    output i2cms_pkg::t_slot_item    o_entry,
    output i2cms_pkg::t_queue_stat   o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    i2cms_pkg::t_slot_item r_mem [DEPTH];
    logic [PTR_W-1:0]      r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]      r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]      r_count,  n_count;

    assign o_stat.full  = (r_count == FULL_CNT);
    assign o_stat.empty = (r_count == '0);
    assign o_entry      = r_mem[r_rd_ptr];

    // Pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

FILE: sv/i2cms_exec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_exec
// Slot engine: runs one bus slot per queued beat and registers the result.
// ----------------------------------------------------------------------------
module i2cms_exec #(
    parameter int RECOVER_PULSES = i2cms_pkg::RECOVER_PULSES
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  i2cms_pkg::t_slot_item    i_entry,
    input  i2cms_pkg::t_queue_stat   i_qstat,
    output logic                     o_pop,
    i2cms_res_if.source              o_res
);

    localparam int CW = i2cms_pkg::BIT_CNT_W;
    localparam int PW = i2cms_pkg::PHASE_W;
    localparam int BW = i2cms_pkg::BYTE_W;
    localparam logic [CW-1:0] PULSE_MAX = CW'(RECOVER_PULSES);
    localparam logic [CW-1:0] BITS_END  = CW'(i2cms_pkg::BYTE_BITS);

    // Sequence state
    i2cms_pkg::t_kind  r_cmd,   n_cmd;
    logic [PW-1:0]     r_phase, n_phase;
    logic [CW-1:0]     r_bits,  n_bits;
    logic [BW-1:0]     r_shift, n_shift;
    logic              r_tail,  n_tail;
    logic              r_scl,   n_scl;
    logic              r_sda,   n_sda;
    logic              r_ack,   n_ack;
    logic              r_stuck, n_stuck;
    logic [BW-1:0]     r_read,  n_read;
    logic              n_done;
    logic              n_rej;

    // Output register
    logic                  r_out_valid;
    i2cms_pkg::t_slot_res  r_res;

    assign o_pop = !i_qstat.empty && (!r_out_valid || o_res.ready);

    // One slot of the active sequence
    always_comb begin
        n_cmd   = r_cmd;
        n_phase = r_phase;
        n_bits  = r_bits;
        n_shift = r_shift;
        n_tail  = r_tail;
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_ack   = r_ack;
        n_stuck = r_stuck;
        n_read  = r_read;
        n_done  = 1'b0;
        n_rej   = 1'b0;

        // Command launch or reject
        if (r_cmd != i2cms_pkg::KIND_TICK) begin
            n_rej = i_entry.is_cmd;
        end else if (i_entry.is_cmd) begin
            n_cmd   = i_entry.kind;
            n_phase = '0;
            n_bits  = '0;
            n_tail  = 1'b0;
            n_shift = i_entry.seed;
        end

        case (n_cmd)
            i2cms_pkg::KIND_TICK: begin
            end
            i2cms_pkg::KIND_START: begin
                case (n_phase)
                    2'd0:    n_sda = 1'b1;
                    2'd1:    n_scl = 1'b1;
                    2'd2:    n_sda = 1'b0;
                    default: begin
                        n_scl  = 1'b0;
                        n_done = 1'b1;
                    end
                endcase
                n_phase = n_phase + 1'b1;
            end
            i2cms_pkg::KIND_STOP: begin
                case (n_phase)
                    2'd0:    n_sda = 1'b0;
                    2'd1:    n_scl = 1'b1;
                    default: begin
                        n_sda  = 1'b1;
                        n_done = 1'b1;
                    end
                endcase
                n_phase = n_phase + 1'b1;
            end
            i2cms_pkg::KIND_WRITE: begin
                if (n_bits >= BITS_END) begin
                    n_sda  = 1'b1;
                    n_done = 1'b1;
                end else if (n_phase == 2'd0) begin
                    n_sda   = n_shift[BW-1];
                    n_shift = {n_shift[BW-2:0], 1'b0};
                    n_phase = 2'd1;
                end else if (n_phase == 2'd1) begin
                    n_scl   = 1'b1;
                    n_phase = 2'd2;
                end else begin
                    n_scl   = 1'b0;
                    n_phase = 2'd0;
                    n_bits  = n_bits + 1'b1;
                end
            end
            i2cms_pkg::KIND_READ: begin
                if (n_bits == '0) begin
                    n_sda   = 1'b1;
                    n_shift = '0;
                    n_bits  = CW'(1);
                    n_phase = 2'd0;
                end else if (n_phase == 2'd0) begin
                    n_scl   = 1'b1;
                    n_shift = {n_shift[BW-2:0], i_entry.sda};
                    n_phase = 2'd1;
                end else begin
                    n_scl   = 1'b0;
                    n_phase = 2'd0;
                    n_bits  = n_bits + 1'b1;
                    if (n_bits > BITS_END) begin
                        n_read = n_shift;
                        n_done = 1'b1;
                    end
                end
            end
            i2cms_pkg::KIND_SEND_ACK: begin
                case (n_phase)
                    2'd0:    n_sda = n_shift[0];
                    2'd1:    n_scl = 1'b1;
                    2'd2:    n_scl = 1'b0;
                    default: begin
                        n_sda  = 1'b1;
                        n_done = 1'b1;
                    end
                endcase
                n_phase = n_phase + 1'b1;
            end
            i2cms_pkg::KIND_RECV_ACK: begin
                case (n_phase)
                    2'd0:    n_sda = 1'b1;
                    2'd1: begin
                        n_scl = 1'b1;
                        n_ack = i_entry.sda;
                    end
                    default: begin
                        n_scl  = 1'b0;
                        n_done = 1'b1;
                    end
                endcase
                n_phase = n_phase + 1'b1;
            end
            i2cms_pkg::KIND_RECOVER: begin
                if (n_tail) begin
                    // Closing: hold SCL high, then a stop condition
                    if (n_phase == 2'd1) begin
                        n_phase = 2'd2;
                    end else if (n_phase == 2'd2) begin
                        n_sda   = 1'b0;
                        n_phase = 2'd3;
                    end else begin
                        n_sda   = 1'b1;
                        n_stuck = !i_entry.sda;
                        n_done  = 1'b1;
                    end
                end else if (n_phase == 2'd0 && n_bits == '0 && n_shift == '0) begin
                    // First slot: is SDA stuck at all
                    if (i_entry.sda) begin
                        n_stuck = 1'b0;
                        n_done  = 1'b1;
                    end else begin
                        n_sda   = 1'b1;
                        n_shift = BW'(1);
                    end
                end else if (n_phase == 2'd0) begin
                    n_scl = 1'b1;
                    if (i_entry.sda || n_bits >= PULSE_MAX) begin
                        n_tail = 1'b1;
                    end
                    n_phase = 2'd1;
                end else if (n_phase == 2'd1) begin
                    n_phase = 2'd2;
                end else if (n_phase == 2'd2) begin
                    n_scl   = 1'b0;
                    n_phase = 2'd3;
                end else begin
                    n_phase = 2'd0;
                    if (n_bits != '1) begin
                        n_bits = n_bits + 1'b1;
                    end
                end
            end
            default: n_done = 1'b1;
        endcase

        if (n_done) begin
            n_cmd   = i2cms_pkg::KIND_TICK;
            n_phase = '0;
            n_bits  = '0;
            n_tail  = 1'b0;
        end
    end

    // Sequence state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd   <= i2cms_pkg::KIND_TICK;
            r_phase <= '0;
            r_bits  <= '0;
            r_shift <= '0;
            r_tail  <= 1'b0;
            r_scl   <= 1'b1;
            r_sda   <= 1'b1;
            r_ack   <= 1'b0;
            r_stuck <= 1'b0;
            r_read  <= '0;
        end else if (o_pop) begin
            r_cmd   <= n_cmd;
            r_phase <= n_phase;
            r_bits  <= n_bits;
            r_shift <= n_shift;
            r_tail  <= n_tail;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
            r_ack   <= n_ack;
            r_stuck <= n_stuck;
            r_read  <= n_read;
        end
    end

    // Result register: loads on every engine step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res.scl_level <= n_scl;
            r_res.sda_level <= n_sda;
            r_res.busy_res  <= (n_cmd != i2cms_pkg::KIND_TICK);
            r_res.done_res  <= n_done;
            r_res.read_byte <= n_read;
            r_res.ack_seen  <= n_ack;
            r_res.bus_stuck <= n_stuck;
            r_res.rejected  <= n_rej;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.scl_level = r_res.scl_level;
    assign o_res.sda_level = r_res.sda_level;
    assign o_res.busy_res  = r_res.busy_res;
    assign o_res.done_res  = r_res.done_res;
    assign o_res.read_byte = r_res.read_byte;
    assign o_res.ack_seen  = r_res.ack_seen;
    assign o_res.bus_stuck = r_res.bus_stuck;
    assign o_res.rejected  = r_res.rejected;

endmodule

FILE: sv/i2c_master_bit_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer
// Open-drain I2C master line sequencer, one bus timing slot per beat.
// ----------------------------------------------------------------------------
//  channel | dir | beat carries                                 | handshake
//  i_item  | in  | kind, write_byte, ack_value, sda_sample      | valid/ready
//  o_res   | out | scl/sda drive, busy, done, read byte, acks,  | valid/ready
//          |     | bus_stuck, rejected                          |
//
// One beat in, one beat out; a new slot is taken every cycle while the
// queue holds a beat and the output is not stalled. A beat passes the queue
// slot, then the engine updates its sequence state and result register.
// Reset (synchronous, active low) idles the engine, releases SCL and SDA
// and empties the queue.
// A stalled output holds the engine; input beats keep landing in the
// queue until it fills.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer #(
    parameter int RECOVER_PULSES = i2cms_pkg::RECOVER_PULSES,
    parameter int QUEUE_DEPTH    = i2cms_pkg::QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    i2cms_item_if.sink   i_item,
    i2cms_res_if.source  o_res
);

    i2cms_pkg::t_queue_stat w_qstat;
    i2cms_pkg::t_slot_item  w_push_entry;
    i2cms_pkg::t_slot_item  w_pop_entry;
    logic                   w_push;
    logic                   w_pop;

    // Front end: accept and classify
    i2cms_front u_front (
        .i_item  (i_item),
        .i_qstat (w_qstat),
        .o_push  (w_push),
        .o_entry (w_push_entry)
    );

    // Decoupling queue
    i2cms_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_pop),
        .o_entry (w_pop_entry),
        .o_stat  (w_qstat)
    );

    // Slot engine
    i2cms_exec #(
        .RECOVER_PULSES (RECOVER_PULSES)
    ) u_exec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_entry (w_pop_entry),
        .i_qstat (w_qstat),
        .o_pop   (w_pop),
        .o_res   (o_res)
    );

endmodule

FILE: sv/i2cms_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_checker
// Port-level checks of the I2C master bit sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module i2cms_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_busy,
    input logic i_done,
    input logic i_rejected,
    input logic i_scl,
    input logic i_sda
);

    // A finished sequence leaves the engine idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_done |-> !i_busy)
        else $error("done reported with busy still set");

    // A drop only happens while a sequence runs in that slot
    a_reject_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_rejected |-> i_busy || i_done)
        else $error("command rejected with no sequence running");

    // A stalled result beat holds its line drives and its busy and done status
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_scl) && $stable(i_sda) && $stable(i_busy)
            && $stable(i_done))
        else $error("result beat changed while stalled");

endmodule

bind i2c_master_bit_sequencer i2cms_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_busy      (o_res.busy_res),
    .i_done      (o_res.done_res),
    .i_rejected  (o_res.rejected),
    .i_scl       (o_res.scl_level),
    .i_sda       (o_res.sda_level)
);
